// ----- src/sm3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_pkg
// shared types, constants and word functions of the sm3 hash engine
// ----------------------------------------------------------------------------
package sm3_pkg;

    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    localparam logic [31:0] T_LOW  = 32'd2045582361;
    localparam logic [31:0] T_HIGH = 32'd2056262026;
    localparam logic [31:0] PAD_MARK = 32'h8000_0000;
    localparam logic [2:0]  VB_FULL  = 3'd4;
    localparam logic [63:0] WORD_BITS = 64'd32;

    localparam logic [31:0] IV_RESET [8] = '{
        32'd1937748463, 32'd1226093241, 32'd389422807, 32'd3669145600,
        32'd2845899964, 32'd375685450, 32'd3822180045, 32'd2968393358
    };

    localparam logic [3:0] CFG_IV_LAST = 4'd7;
    localparam logic [3:0] SLOT_LEN_HI = 4'd14;
    localparam logic [3:0] SLOT_LEN_LO = 4'd15;
    localparam logic [5:0] ROUND_LAST  = 6'd63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_INIT,
        ST_ROUND,
        ST_FOLD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  vb;
        logic        last;
    } t_item;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    function automatic logic [31:0] p0f(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1f(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

`default_nettype wire

// ----- src/sm3_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_front
// input word queue; clamps the byte count of the final word
// ----------------------------------------------------------------------------
module sm3_front import sm3_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_valid_bytes,
    input  wire logic        i_end_of_message,
    output logic             o_item_vld,
    output t_item            o_item,
    input  wire logic        i_item_take
);

    t_item              r_mem [FQ_DEPTH];
    logic [FQ_AW-1:0]   r_wr;
    logic [FQ_AW-1:0]   r_rd;
    logic [FQ_CW-1:0]   r_cnt;
    logic               w_push;
    logic               w_pop;
    t_item              w_item;

    assign o_full     = (r_cnt == FQ_CW'(FQ_DEPTH));
    assign o_item_vld = (r_cnt != '0);
    assign o_item     = r_mem[r_rd];
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_item_take && o_item_vld;

    always_comb begin
        w_item.data = i_data_word;
        w_item.last = i_end_of_message;
        w_item.vb   = (i_valid_bytes > VB_FULL) ? VB_FULL : i_valid_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= FQ_AW'((FQ_AW+1)'(r_wr) + 1'b1);
            end
            if (w_pop) begin
                r_rd <= FQ_AW'((FQ_AW+1)'(r_rd) + 1'b1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_item;
        end
    end

endmodule

`default_nettype wire

// ----- src/sm3_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_core
// block assembly, padding, message expansion and the 64 compression rounds
// ----------------------------------------------------------------------------
module sm3_core import sm3_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_item_vld,
    input  wire t_item        i_item,
    output logic              o_item_take,
    input  wire logic         i_cfg_we,
    input  wire logic [3:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    output logic              o_dig_load,
    output logic [255:0]      o_digest,
    input  wire logic         i_out_busy,
    output t_state            o_state
);

    t_state       r_state, n_state;
    logic [31:0]  r_iv    [8];
    logic [31:0]  r_chain [8];
    logic [31:0]  n_chain [8];
    logic [31:0]  r_regs  [8];
    logic [31:0]  n_regs  [8];
    logic [31:0]  r_win   [16];
    logic [5:0]   r_ridx, n_ridx;
    logic [3:0]   r_slot, n_slot;
    logic [63:0]  r_bits, n_bits;
    logic         r_in_msg, n_in_msg;
    logic         r_pad, n_pad;
    logic         r_pend, n_pend;
    logic         r_len, n_len;
    logic         r_done, n_done;

    logic         w_we;
    logic [31:0]  w_wdata;
    logic [3:0]   w_sb;
    logic [63:0]  w_bb;
    logic         w_shift;
    logic [31:0]  w_masked;
    logic [31:0]  w_wnew;
    logic [31:0]  w_tj, w_a12, w_ss1, w_ss2, w_ff, w_gg, w_tt1, w_tt2;

    assign o_state = r_state;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            o_digest[255-32*k -: 32] = r_chain[k];
        end
    end

    // final word: keep the valid bytes, then the marker byte if the word is not full
    always_comb begin
        case (i_item.vb)
            3'd0:    w_masked = PAD_MARK;
            3'd1:    w_masked = {i_item.data[31:24], 8'h80, 16'h0};
            3'd2:    w_masked = {i_item.data[31:16], 8'h80, 8'h0};
            3'd3:    w_masked = {i_item.data[31:8], 8'h80};
            default: w_masked = i_item.data;
        endcase
    end

    // one round
    always_comb begin
        w_tj  = (r_ridx < 6'd16) ? T_LOW : T_HIGH;
        w_a12 = rotl(r_regs[0], 5'd12);
        w_ss1 = rotl(w_a12 + r_regs[4] + rotl(w_tj, r_ridx[4:0]), 5'd7);
        w_ss2 = w_ss1 ^ w_a12;
        if (r_ridx < 6'd16) begin
            w_ff = r_regs[0] ^ r_regs[1] ^ r_regs[2];
            w_gg = r_regs[4] ^ r_regs[5] ^ r_regs[6];
        end else begin
            w_ff = (r_regs[0] & r_regs[1]) | (r_regs[0] & r_regs[2])
                 | (r_regs[1] & r_regs[2]);
            w_gg = (r_regs[4] & r_regs[5]) | (~r_regs[4] & r_regs[6]);
        end
        w_tt1 = w_ff + r_regs[3] + w_ss2 + (r_win[0] ^ r_win[4]);
        w_tt2 = w_gg + r_regs[7] + w_ss1 + r_win[0];
        w_wnew = p1f(r_win[0] ^ r_win[7] ^ rotl(r_win[13], 5'd15))
               ^ rotl(r_win[3], 5'd7) ^ r_win[10];
    end

    always_comb begin
        n_state  = r_state;
        n_chain  = r_chain;
        n_regs   = r_regs;
        n_ridx   = r_ridx;
        n_slot   = r_slot;
        n_bits   = r_bits;
        n_in_msg = r_in_msg;
        n_pad    = r_pad;
        n_pend   = r_pend;
        n_len    = r_len;
        n_done   = r_done;
        w_we     = 1'b0;
        w_wdata  = '0;
        w_sb     = r_slot;
        w_bb     = r_bits;
        w_shift  = 1'b0;
        o_item_take = 1'b0;
        o_dig_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_item_vld) begin
                    o_item_take = 1'b1;
                    if (!r_in_msg) begin
                        n_chain = r_iv;
                        w_sb    = '0;
                        w_bb    = '0;
                    end
                    w_we   = 1'b1;
                    n_slot = w_sb + 1'b1;
                    if (!i_item.last) begin
                        w_wdata  = i_item.data;
                        n_bits   = w_bb + WORD_BITS;
                        n_in_msg = 1'b1;
                    end else begin
                        w_wdata  = w_masked;
                        n_bits   = w_bb + {58'b0, i_item.vb, 3'b0};
                        n_pend   = (i_item.vb == VB_FULL);
                        n_pad    = 1'b1;
                        n_len    = 1'b0;
                        n_done   = 1'b0;
                        n_in_msg = 1'b0;
                        n_state  = ST_PAD;
                    end
                    if (w_sb == SLOT_LEN_LO) begin
                        n_state = ST_INIT;
                    end
                end
            end
            ST_PAD: begin
                w_we   = 1'b1;
                n_slot = r_slot + 1'b1;
                if (r_slot == SLOT_LEN_HI) begin
                    if (r_pend) begin
                        w_wdata = PAD_MARK;
                        n_pend  = 1'b0;
                    end else begin
                        w_wdata = r_bits[63:32];
                        n_len   = 1'b1;
                    end
                end else if (r_slot == SLOT_LEN_LO && r_len) begin
                    w_wdata = r_bits[31:0];
                    n_done  = 1'b1;
                end else if (r_pend) begin
                    w_wdata = PAD_MARK;
                    n_pend  = 1'b0;
                end
                if (r_slot == SLOT_LEN_LO) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                n_regs  = r_chain;
                n_ridx  = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                w_shift   = 1'b1;
                n_regs[3] = r_regs[2];
                n_regs[2] = rotl(r_regs[1], 5'd9);
                n_regs[1] = r_regs[0];
                n_regs[0] = w_tt1;
                n_regs[7] = r_regs[6];
                n_regs[6] = rotl(r_regs[5], 5'd19);
                n_regs[5] = r_regs[4];
                n_regs[4] = p0f(w_tt2);
                n_ridx    = r_ridx + 1'b1;
                if (r_ridx == ROUND_LAST) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                for (int k = 0; k < 8; k++) begin
                    n_chain[k] = r_chain[k] ^ r_regs[k];
                end
                if (!r_pad) begin
                    n_state = ST_IDLE;
                end else if (r_done) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_DONE: begin
                if (!i_out_busy) begin
                    o_dig_load = 1'b1;
                    n_pad      = 1'b0;
                    n_len      = 1'b0;
                    n_done     = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_chain  <= '{default: '0};
            r_regs   <= '{default: '0};
            r_ridx   <= '0;
            r_slot   <= '0;
            r_bits   <= '0;
            r_in_msg <= 1'b0;
            r_pad    <= 1'b0;
            r_pend   <= 1'b0;
            r_len    <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_chain  <= n_chain;
            r_regs   <= n_regs;
            r_ridx   <= n_ridx;
            r_slot   <= n_slot;
            r_bits   <= n_bits;
            r_in_msg <= n_in_msg;
            r_pad    <= n_pad;
            r_pend   <= n_pend;
            r_len    <= n_len;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= IV_RESET;
        end else if (i_cfg_we && i_cfg_index <= CFG_IV_LAST) begin
            r_iv[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    // schedule window, slides one word per round, else takes a written word at its slot
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            for (int k = 0; k < 15; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[15] <= w_wnew;
        end else if (w_we) begin
            r_win[w_sb] <= w_wdata;
        end
    end

endmodule

`default_nettype wire

// ----- src/sm3_out.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_out
// digest holding buffer, hands out four 64-bit words
// ----------------------------------------------------------------------------
module sm3_out import sm3_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_load,
    input  wire logic [255:0] i_digest,
    output logic              o_busy,
    output logic              o_empty,
    input  wire logic         i_pop,
    output logic [63:0]       o_digest_chunk,
    output logic              o_chunk_last
);

    logic [63:0] r_buf [4];
    logic [1:0]  r_cnt;
    logic        r_vld;

    assign o_busy         = r_vld;
    assign o_empty        = !r_vld;
    assign o_digest_chunk = r_buf[r_cnt];
    assign o_chunk_last   = (r_cnt == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_cnt <= '0;
        end else if (i_load) begin
            r_vld <= 1'b1;
            r_cnt <= '0;
        end else if (i_pop && r_vld) begin
            r_cnt <= r_cnt + 1'b1;
            if (o_chunk_last) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < 4; k++) begin
                r_buf[k] <= i_digest[255-64*k -: 64];
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/sm3_hash_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_hash_engine
// sm3-style 256-bit hash over a stream of big-endian 32-bit message words
// ----------------------------------------------------------------------------
// Words enter a two-deep queue and are taken by the compression engine one
// per cycle while a block fills. Each 16-word block then passes a load
// step, 64 rounds (one round per cycle through a single round unit) and a
// fold step. The final word adds the padding words (one per cycle) and one
// or two further compressions; the digest is then moved to an output
// buffer that hands out four 64-bit words while the engine takes the next
// message. Config writes are always accepted; iv changes apply at the next
// message start.
// ----------------------------------------------------------------------------
module sm3_hash_engine import sm3_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_valid_bytes,
    input  wire logic        i_end_of_message,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [63:0]      o_digest_chunk,
    output logic             o_chunk_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic         w_item_vld;
    t_item        w_item;
    logic         w_item_take;
    logic         w_dig_load;
    logic [255:0] w_digest;
    logic         w_out_busy;
    t_state       w_state;

    assign o_cfg_ready = 1'b1;

    sm3_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_data_word      (i_data_word),
        .i_valid_bytes    (i_valid_bytes),
        .i_end_of_message (i_end_of_message),
        .o_item_vld       (w_item_vld),
        .o_item           (w_item),
        .i_item_take      (w_item_take)
    );

    sm3_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_vld  (w_item_vld),
        .i_item      (w_item),
        .o_item_take (w_item_take),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_dig_load  (w_dig_load),
        .o_digest    (w_digest),
        .i_out_busy  (w_out_busy),
        .o_state     (w_state)
    );

    sm3_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_dig_load),
        .i_digest       (w_digest),
        .o_busy         (w_out_busy),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_digest_chunk (o_digest_chunk),
        .o_chunk_last   (o_chunk_last)
    );

    // popping the final word drains the buffer
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && o_chunk_last) |=> o_empty)
        else $error("output not empty after final word");

    // a digest is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dig_load |-> !w_out_busy)
        else $error("digest loaded while output busy");

    // rounds only end in the fold step
    a_round_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == ST_ROUND) |=> (w_state == ST_ROUND || w_state == ST_FOLD))
        else $error("round sequence broken");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sm3 hash engine: random and directed messages
// are pushed through the input queue, every digest word is compared with a
// behavioural hash model run on each accepted word, iv registers are varied
// ----------------------------------------------------------------------------
module tb;
    import sm3_pkg::*;

    typedef struct {
        logic [31:0] data;
        logic [2:0]  vb;
        logic        last;
    } msg_word_t;

    typedef struct {
        logic [63:0] chunk;
        logic        last;
    } digest_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [31:0] data_word = '0;
    logic [2:0]  valid_bytes = '0;
    logic        end_of_msg = 1'b0;
    logic        pop = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [3:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        o_full, o_empty, o_chunk_last, o_cfg_ready;
    logic [63:0] o_digest_chunk;

    msg_word_t    word_queue[$];
    digest_word_t digest_queue[$];
    int send_idle = 0;
    int recv_idle = 0;
    int issue_cnt = 0;
    int accept_cnt = 0;
    int hold_total = 0;
    int held = 0;
    int errors = 0;

    logic [31:0] iv_copy [8];
    logic [31:0] chain [8];
    logic [31:0] window [16];
    int          slot;
    logic [63:0] bit_len;
    logic        in_msg;

    sm3_hash_engine uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(o_full),
        .i_data_word(data_word), .i_valid_bytes(valid_bytes),
        .i_end_of_message(end_of_msg), .o_empty(o_empty), .i_pop(pop),
        .o_digest_chunk(o_digest_chunk), .o_chunk_last(o_chunk_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        n = n & 31;
        if (n == 0) return x;
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic run_block(input logic [511:0] blk);
        logic [31:0] w [68];
        logic [31:0] r [8];
        logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 68; i++) begin
            tt1 = w[i - 16] ^ w[i - 9] ^ rol(w[i - 3], 15);
            w[i] = tt1 ^ rol(tt1, 15) ^ rol(tt1, 23) ^ rol(w[i - 13], 7) ^ w[i - 6];
        end
        for (int i = 0; i < 8; i++) r[i] = chain[i];
        for (int j = 0; j < 64; j++) begin
            tj  = (j < 16) ? 32'd2045582361 : 32'd2056262026;
            a12 = rol(r[0], 12);
            ss1 = rol(a12 + r[4] + rol(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ff = r[0] ^ r[1] ^ r[2];
                gg = r[4] ^ r[5] ^ r[6];
            end else begin
                ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                gg = (r[4] & r[5]) | (~r[4] & r[6]);
            end
            tt1 = ff + r[3] + ss2 + (w[j] ^ w[j + 4]);
            tt2 = gg + r[7] + ss1 + w[j];
            r[3] = r[2]; r[2] = rol(r[1], 9); r[1] = r[0]; r[0] = tt1;
            r[7] = r[6]; r[6] = rol(r[5], 19); r[5] = r[4];
            r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
        end
        for (int i = 0; i < 8; i++) chain[i] = chain[i] ^ r[i];
    endtask

    task automatic hash_word(input logic [31:0] d, input logic [2:0] vb_in,
                             input logic last);
        logic [1023:0] pad_buf;
        logic [511:0]  blk;
        int vb, p, nblk;
        digest_word_t dw;
        if (!in_msg) begin
            for (int i = 0; i < 8; i++) chain[i] = iv_copy[i];
            slot = 0;
            bit_len = '0;
            in_msg = 1'b1;
        end
        if (!last) begin
            window[slot] = d;
            bit_len += 64'd32;
            slot++;
            if (slot == 16) begin
                for (int i = 0; i < 16; i++) blk[511 - 32 * i -: 32] = window[i];
                run_block(blk);
                slot = 0;
            end
            return;
        end
        vb = (vb_in > 3'd4) ? 4 : int'(vb_in);
        bit_len += 64'(vb * 8);
        pad_buf = '0;
        for (int i = 0; i < slot; i++) pad_buf[1023 - 32 * i -: 32] = window[i];
        p = slot * 4;
        for (int i = 0; i < vb; i++) pad_buf[1023 - 8 * (p + i) -: 8] = d[31 - 8 * i -: 8];
        p += vb;
        pad_buf[1023 - 8 * p -: 8] = 8'h80;
        nblk = (p + 9 <= 64) ? 1 : 2;
        pad_buf[1023 - 8 * (nblk * 64 - 8) -: 64] = bit_len;
        for (int b = 0; b < nblk; b++) run_block(pad_buf[1023 - 512 * b -: 512]);
        for (int k = 0; k < 4; k++) begin
            dw.chunk = {chain[2 * k], chain[2 * k + 1]};
            dw.last  = (k == 3);
            digest_queue = {digest_queue, dw};
        end
        slot = 0;
        bit_len = '0;
        in_msg = 1'b0;
    endtask

    // word driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && accept_cnt != issue_cnt)) begin
            if (word_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
                data_word   <= word_queue[0].data;
                valid_bytes <= word_queue[0].vb;
                end_of_msg  <= word_queue[0].last;
                void'(word_queue.pop_front());
                push <= 1'b1;
                issue_cnt <= issue_cnt + 1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (held < hold_total) begin
            held <= held + 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !o_full) begin
                hash_word(data_word, valid_bytes, end_of_msg);
                accept_cnt <= accept_cnt + 1;
            end
            if (pop && !o_empty) begin
                if (digest_queue.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected word %h", o_digest_chunk);
                end else begin
                    if (o_digest_chunk !== digest_queue[0].chunk
                        || o_chunk_last !== digest_queue[0].last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp %h/%b got %h/%b",
                                     digest_queue[0].chunk, digest_queue[0].last,
                                     o_digest_chunk, o_chunk_last);
                    end
                    void'(digest_queue.pop_front());
                end
            end
        end
    end

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= CFG_IV_LAST) iv_copy[idx[2:0]] = val;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_message(input int n, input logic [2:0] vb, input logic [31:0] tail);
        msg_word_t m;
        for (int i = 0; i < n; i++) begin
            m.data = $urandom;
            m.vb = 3'($urandom_range(7));
            m.last = 1'b0;
            word_queue = {word_queue, m};
        end
        m.data = tail;
        m.vb = vb;
        m.last = 1'b1;
        word_queue = {word_queue, m};
    endtask

    task automatic drain;
        do @(posedge i_clk);
        while (word_queue.size() != 0 || accept_cnt != issue_cnt || digest_queue.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_messages(input int n_words);
        int cnt, len, pick;
        cnt = 0;
        while (cnt < n_words) begin
            pick = $urandom_range(9);
            if (pick < 5) len = $urandom_range(12);
            else if (pick < 8) len = $urandom_range(17, 12);
            else len = $urandom_range(40, 28);
            add_message(len, 3'($urandom_range(7)), $urandom);
            cnt += len + 1;
        end
    endtask

    initial begin
        for (int i = 0; i < 8; i++) iv_copy[i] = IV_RESET[i];
        in_msg = 1'b0;
        slot = 0;
        bit_len = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty message, single words, padding edges
        send_idle = 20;
        recv_idle = 88;
        add_message(0, 3'd0, 32'hFFFF_FFFF);
        for (int v = 1; v < 8; v++) add_message(0, v[2:0], 32'hFFFF_FFFF);
        add_message(0, 3'd2, 32'h0000_0000);
        add_message(13, 3'd3, $urandom);
        drain();

        random_messages(25);
        drain();

        write_reg(4'd0, '0); write_reg(4'd1, '0); write_reg(4'd2, '0); write_reg(4'd3, '0);
        write_reg(4'd4, '0); write_reg(4'd5, '0); write_reg(4'd6, '0); write_reg(4'd7, '0);
        for (int i = 8; i < 16; i++) write_reg(i[3:0], $urandom);
        send_idle = 88;
        recv_idle = 20;
        add_message(14, 3'd0, $urandom);
        add_message(16, 3'd4, $urandom);
        hold_total = 400;
        random_messages(10);
        drain();

        for (int i = 0; i < 8; i++) write_reg(i[3:0], 32'hFFFF_FFFF);
        random_messages(12);
        drain();

        for (int i = 0; i < 8; i++) write_reg(i[3:0], $urandom);
        send_idle = 0;
        recv_idle = 0;
        random_messages(25);
        drain();

        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: FAIL");
        $finish;
    end

endmodule
